// File: design/msb_first_bitstream_reader_defines.svh
// assertion helpers used by the bit reader core module
`ifndef MSB_FIRST_BITSTREAM_READER_DEFINES_SVH
`define MSB_FIRST_BITSTREAM_READER_DEFINES_SVH

// checked only out of reset
`define MSBR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MSBR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/msbr_pkg.sv
package msbr_pkg;

    localparam int WORD_WIDTH   = 32;
    localparam int BUFFER_WORDS = 2;
    localparam int CAP_BITS     = WORD_WIDTH * BUFFER_WORDS;
    localparam int CNT_W        = $clog2(CAP_BITS + 1);

    localparam logic [5:0] NBITS_MAX = 6'd32;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [CAP_BITS-1:0]   buf_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [2:0] {
        KIND_PUSH  = 3'd0,
        KIND_GET   = 3'd1,
        KIND_PEEK  = 3'd2,
        KIND_SKIP  = 3'd3,
        KIND_ALIGN = 3'd4,
        KIND_FLUSH = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_STARVED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] word;
        logic [5:0]  nbits;
    } item_t;

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
        logic [6:0]  bits_available;
        logic [31:0] bit_position;
    } result_t;

    // right-aligned mask of n ones, n up to 32
    function automatic logic [31:0] read_mask(logic [5:0] n);
        logic [32:0] m;
        m = (33'd1 << n) - 33'd1;
        return m[31:0];
    endfunction

endpackage

// File: design/msbr_in_stage.sv
module msbr_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  msbr_pkg::item_t in_item,
    input  logic           advance,
    output logic           in_stall,
    output logic           item_valid,
    output msbr_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    msbr_pkg::item_t item_reg;
    logic            load;

    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/msbr_core.sv
`include "msb_first_bitstream_reader_defines.svh"

module msbr_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  msbr_pkg::item_t   item,
    output msbr_pkg::result_t result
);

    msbr_pkg::buf_t   buf_reg;
    msbr_pkg::buf_t   buf_next;
    msbr_pkg::cnt_t   fill_reg;
    msbr_pkg::cnt_t   fill_next;
    logic [31:0]      cons_reg;
    logic [31:0]      cons_next;

    logic [5:0]       n_sat;
    msbr_pkg::cnt_t   n_cnt;
    msbr_pkg::cnt_t   shift;
    msbr_pkg::buf_t   front;
    msbr_pkg::word_t  w;
    logic [2:0]       drop;
    logic [31:0]      value;
    msbr_pkg::status_t status;
    logic [31:0]      fill_ext;

    logic             push_ok;
    logic             drain_step;
    logic             fill_in_range;
    msbr_pkg::cnt_t   fill_grown;
    logic [31:0]      pos_sum;

    assign n_sat = (item.nbits > msbr_pkg::NBITS_MAX) ? msbr_pkg::NBITS_MAX : item.nbits;
    assign n_cnt = msbr_pkg::cnt_t'(n_sat);
    // oldest valid bit sits at fill-1, so the front field starts at fill-n
    assign shift = fill_reg - n_cnt;
    assign front = buf_reg >> shift;
    assign w     = msbr_pkg::word_t'(item.word);
    // bits left to the next byte boundary of the stream
    assign drop  = 3'd0 - cons_reg[2:0];

    always_comb
    begin
        buf_next  = buf_reg;
        fill_next = fill_reg;
        cons_next = cons_reg;
        value     = 32'd0;
        status    = msbr_pkg::ST_OK;
        unique case (msbr_pkg::kind_t'(item.kind))
            msbr_pkg::KIND_PUSH:
            begin
                if (fill_reg > msbr_pkg::cnt_t'(msbr_pkg::CAP_BITS - msbr_pkg::WORD_WIDTH))
                begin
                    status = msbr_pkg::ST_FULL;
                end
                else
                begin
                    buf_next  = {buf_reg[msbr_pkg::CAP_BITS-msbr_pkg::WORD_WIDTH-1:0], w};
                    fill_next = fill_reg + msbr_pkg::cnt_t'(msbr_pkg::WORD_WIDTH);
                end
            end
            msbr_pkg::KIND_GET, msbr_pkg::KIND_PEEK, msbr_pkg::KIND_SKIP:
            begin
                if (n_cnt > fill_reg)
                begin
                    status = msbr_pkg::ST_STARVED;
                end
                else
                begin
                    if (msbr_pkg::kind_t'(item.kind) != msbr_pkg::KIND_SKIP)
                    begin
                        value = 32'(front) & msbr_pkg::read_mask(n_sat);
                    end
                    if (msbr_pkg::kind_t'(item.kind) != msbr_pkg::KIND_PEEK)
                    begin
                        fill_next = fill_reg - n_cnt;
                        cons_next = cons_reg + 32'(n_sat);
                    end
                end
            end
            msbr_pkg::KIND_ALIGN:
            begin
                if (msbr_pkg::cnt_t'(drop) > fill_reg)
                begin
                    status = msbr_pkg::ST_STARVED;
                end
                else
                begin
                    fill_next = fill_reg - msbr_pkg::cnt_t'(drop);
                    cons_next = cons_reg + 32'(drop);
                end
            end
            msbr_pkg::KIND_FLUSH:
            begin
                fill_next = '0;
                cons_next = cons_reg + 32'(fill_reg);
            end
            default:
            begin
                status = msbr_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            fill_reg <= '0;
            cons_reg <= 32'd0;
        end
        else if (step)
        begin
            buf_reg  <= buf_next;
            fill_reg <= fill_next;
            cons_reg <= cons_next;
        end
    end

    assign fill_ext = 32'(fill_next);

    assign result.value          = value;
    assign result.status         = status;
    assign result.bits_available = fill_ext[6:0];
    assign result.bit_position   = cons_next;

    assign push_ok       = step && (item.kind == msbr_pkg::KIND_PUSH) &&
                           (status == msbr_pkg::ST_OK);
    assign drain_step    = step && (item.kind != msbr_pkg::KIND_PUSH);
    assign fill_in_range = fill_reg <= msbr_pkg::cnt_t'(msbr_pkg::CAP_BITS);
    assign fill_grown    = fill_reg + msbr_pkg::cnt_t'(msbr_pkg::WORD_WIDTH);
    // consumed plus buffered only moves on a push
    assign pos_sum       = cons_reg + 32'(fill_reg);

    `MSBR_ASSERT_ALWAYS(a_fill_cap, !rst_n || fill_in_range, "fill beyond capacity")
    `MSBR_ASSERT(a_idle_hold, !step |=> $stable({fill_reg, cons_reg}), "state moved without a word")
    `MSBR_ASSERT(a_push_fill, push_ok |=> fill_reg == $past(fill_grown), "push did not add a word")
    `MSBR_ASSERT(a_consume_track, drain_step |=> pos_sum == $past(pos_sum), "fill and position drift")

endmodule

// File: design/msb_first_bitstream_reader.sv
// channel  signals                            direction  accepted when
// in       in_valid, in_stall, kind/word/nbits  sink       in_valid && !in_stall
// out      out_valid, out_stall, value/status/   source     out_valid && !out_stall
//          bits_available/bit_position
//
// one word per cycle while out_stall is low; a word passes the input then the result register
// the barrel shift over the bit buffer sits between the input register and result register
// rst_n clears the bit buffer, fill count, bit position and both valid flags
// a stalled result holds the pipeline; the input register takes one more word, and
// in_stall rises only while both registers hold words and out_stall is high
module msb_first_bitstream_reader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] word,
    input  logic [5:0]  nbits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    output logic [1:0]  status,
    output logic [6:0]  bits_available,
    output logic [31:0] bit_position
);

    msbr_pkg::item_t   in_item;
    msbr_pkg::item_t   item;
    logic              item_valid;
    logic              advance;
    msbr_pkg::result_t result;
    msbr_pkg::result_t result_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign in_item.kind  = kind;
    assign in_item.word  = word;
    assign in_item.nbits = nbits;

    // item moves on when the result register is free or drains this cycle
    assign advance = item_valid && (!out_valid_reg || !out_stall);

    msbr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .advance    (advance),
        .in_stall   (in_stall),
        .item_valid (item_valid),
        .item       (item)
    );

    msbr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item),
        .result (result)
    );

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign value          = result_reg.value;
    assign status         = result_reg.status;
    assign bits_available = result_reg.bits_available;
    assign bit_position   = result_reg.bit_position;

endmodule

// File: tb/tb_msb_first_bitstream_reader.sv
`timescale 1ns / 1ps

module tb_msb_first_bitstream_reader;

    // kind codes the block does not define, expected to act as no-ops
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_ITEMS  = 60;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    class bit_reader_tracker;
        logic [msbr_pkg::CAP_BITS-1:0] bits;
        logic [6:0]                    fill;
        logic [31:0]                   position;
        msbr_pkg::result_t             answers_due[$];
        int                            errors;

        function new();
            bits     = '0;
            fill     = '0;
            position = '0;
            errors   = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void drop_front(logic [6:0] n);
            fill     = fill - n;
            position = position + 32'(n);
        endfunction

        // advance the predicted reader by one accepted word
        function void note_request(logic [2:0] k, logic [31:0] w, logic [5:0] n);
            msbr_pkg::result_t             r;
            logic [5:0]                    cnt;
            logic [2:0]                    pad;
            logic [msbr_pkg::CAP_BITS-1:0] shifted;
            logic [32:0]                   mask;
            cnt      = (n > msbr_pkg::NBITS_MAX) ? msbr_pkg::NBITS_MAX : n;
            r.value  = '0;
            r.status = msbr_pkg::ST_OK;
            unique case (k)
                msbr_pkg::KIND_PUSH:
                begin
                    if (fill + msbr_pkg::WORD_WIDTH > msbr_pkg::CAP_BITS)
                        r.status = msbr_pkg::ST_FULL;
                    else
                    begin
                        bits = {bits[msbr_pkg::CAP_BITS-msbr_pkg::WORD_WIDTH-1:0], w};
                        fill = fill + 7'(msbr_pkg::WORD_WIDTH);
                    end
                end
                msbr_pkg::KIND_GET, msbr_pkg::KIND_PEEK:
                begin
                    if (7'(cnt) > fill)
                        r.status = msbr_pkg::ST_STARVED;
                    else
                    begin
                        // oldest bit sits at fill-1, so the front cnt bits end at fill-cnt
                        shifted = bits >> (fill - 7'(cnt));
                        mask    = (33'd1 << cnt) - 33'd1;
                        r.value = shifted[31:0] & mask[31:0];
                        if (k == msbr_pkg::KIND_GET)
                            drop_front(7'(cnt));
                    end
                end
                msbr_pkg::KIND_SKIP:
                begin
                    if (7'(cnt) > fill)
                        r.status = msbr_pkg::ST_STARVED;
                    else
                        drop_front(7'(cnt));
                end
                msbr_pkg::KIND_ALIGN:
                begin
                    pad = 3'd0 - position[2:0];
                    if (7'(pad) > fill)
                        r.status = msbr_pkg::ST_STARVED;
                    else
                        drop_front(7'(pad));
                end
                msbr_pkg::KIND_FLUSH:
                    drop_front(fill);
                default:
                    ;
            endcase
            r.bits_available = fill;
            r.bit_position   = position;
            answers_due.push_back(r);
        endfunction

        task check_answer(logic [31:0] v, logic [1:0] s, logic [6:0] a, logic [31:0] p);
            msbr_pkg::result_t r;
            if (answers_due.size() == 0)
            begin
                report($sformatf("result with none pending: value=%h status=%0d", v, s));
                return;
            end
            r = answers_due.pop_front();
            if (v !== r.value)
                report($sformatf("value %h, predicted %h", v, r.value));
            if (s !== r.status)
                report($sformatf("status %0d, predicted %s", s, r.status.name()));
            if (a !== r.bits_available)
                report($sformatf("bits_available %0d, predicted %0d", a, r.bits_available));
            if (p !== r.bit_position)
                report($sformatf("bit_position %0d, predicted %0d", p, r.bit_position));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [31:0] word;
    logic [5:0]  nbits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] value;
    logic [1:0]  status;
    logic [6:0]  bits_available;
    logic [31:0] bit_position;

    bit_reader_tracker tracker = new();

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_off_now = 1'b0;
    int cycle_count;

    msb_first_bitstream_reader i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .word           (word),
        .nbits          (nbits),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .status         (status),
        .bits_available (bits_available),
        .bit_position   (bit_position)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // offer one word and hold it until it is taken
    task automatic send_item(input logic [2:0] k, input logic [31:0] w, input logic [5:0] n);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        word     <= w;
        nbits    <= n;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_request(k, w, n);
    endtask

    // receiver side: random stall bursts plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_now)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_now = 1'b0;
                out_stall <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_answer(value, status, bits_available, bit_position);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, tracker.answers_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int          pick;
        int          avail;
        logic [2:0]  fk;
        logic [31:0] fw;
        logic [5:0]  fn;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        kind     = msbr_pkg::KIND_PUSH;
        word     = '0;
        nbits    = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty buffer corners
        send_item(msbr_pkg::KIND_GET,   32'h0,         6'd0);
        send_item(msbr_pkg::KIND_GET,   32'h0,         6'd1);
        send_item(msbr_pkg::KIND_PEEK,  32'h0,         6'd32);
        send_item(msbr_pkg::KIND_SKIP,  32'h0,         6'd63);
        send_item(msbr_pkg::KIND_SKIP,  32'h0,         6'd0);
        send_item(msbr_pkg::KIND_ALIGN, 32'h0,         6'd0);
        send_item(KIND_SPARE_LO,        32'h0,         6'd5);
        send_item(KIND_SPARE_HI,        32'hFFFF_FFFF, 6'd63);
        // fill up, then one push too many
        send_item(msbr_pkg::KIND_PUSH,  32'hFFFF_FFFF, 6'd0);
        send_item(msbr_pkg::KIND_PUSH,  32'h0000_0000, 6'd63);
        send_item(msbr_pkg::KIND_PUSH,  32'hA5A5_A5A5, 6'd0);
        send_item(msbr_pkg::KIND_PEEK,  32'h0,         6'd32);
        // count above 32 saturates
        send_item(msbr_pkg::KIND_GET,   32'h0,         6'd63);
        send_item(msbr_pkg::KIND_PUSH,  32'h8000_0001, 6'd0);
        send_item(msbr_pkg::KIND_GET,   32'h0,         6'd33);
        send_item(msbr_pkg::KIND_GET,   32'h0,         6'd1);
        send_item(msbr_pkg::KIND_ALIGN, 32'h0,         6'd0);
        send_item(msbr_pkg::KIND_SKIP,  32'h0,         6'd20);
        send_item(msbr_pkg::KIND_ALIGN, 32'h0,         6'd0);
        // partial fill refuses a whole word
        send_item(msbr_pkg::KIND_PUSH,  32'h1234_5678, 6'd0);
        send_item(msbr_pkg::KIND_GET,   32'h0,         6'd3);
        send_item(msbr_pkg::KIND_PUSH,  32'hDEAD_BEEF, 6'd0);
        send_item(msbr_pkg::KIND_PUSH,  32'hCAFE_F00D, 6'd0);
        send_item(msbr_pkg::KIND_PEEK,  32'h0,         6'd32);
        send_item(msbr_pkg::KIND_FLUSH, 32'h0,         6'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                hold_off_now = 1'b1;
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            pick  = $urandom_range(0, 99);
            avail = (tracker.fill > 7'd32) ? 32 : int'(tracker.fill);
            fw    = $urandom;
            // mostly counts that fit, now and then anything the field holds
            if ($urandom_range(0, 6) == 0)
                fn = 6'($urandom_range(0, 63));
            else
                fn = 6'($urandom_range(0, avail));
            if (pick < 4)
                fk = 3'($urandom_range(0, 7));
            else if (pick < 30 || (tracker.fill <= 7'd32 && pick < 50))
                fk = msbr_pkg::KIND_PUSH;
            else if (pick < 66)
                fk = msbr_pkg::KIND_GET;
            else if (pick < 80)
                fk = msbr_pkg::KIND_PEEK;
            else if (pick < 89)
                fk = msbr_pkg::KIND_SKIP;
            else if (pick < 96)
                fk = msbr_pkg::KIND_ALIGN;
            else
                fk = msbr_pkg::KIND_FLUSH;
            send_item(fk, fw, fn);
        end
        in_valid <= 1'b0;

        while (tracker.answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
